>>> sv/shc_pkg.sv
// ============================================================================
// shc_pkg
// Shared types, constants and helpers for the signed header carver.
// ============================================================================
`default_nettype none

package shc_pkg;

    // Header layout (byte offsets from the first magic byte)
    localparam int HDR_LEN   = 'h500;
    localparam int TYPE_OFS  = 'h344;
    localparam int TITLE_OFS = 'h360;
    localparam int VER_OFS   = 'h364;

    // Delay line depths: each stage waits for the last byte of its field
    localparam int MAGIC_DEPTH = TYPE_OFS;
    localparam int TYPED_DEPTH = VER_OFS - TYPE_OFS;
    localparam int FINAL_DEPTH = (HDR_LEN - 1) - (VER_OFS + 3);

    localparam int MAG_AW = $clog2(MAGIC_DEPTH);
    localparam int TYP_AW = $clog2(TYPED_DEPTH);
    localparam int FIN_AW = $clog2(FINAL_DEPTH);
    localparam int FILL_W = $clog2(MAGIC_DEPTH + 1);

    localparam logic [7:0] MAX_VERSION_RST = 8'd2;

    // Magic words, big-endian as they appear on the stream
    localparam logic [31:0] MAGIC_CON  = 32'h434F_4E20;
    localparam logic [31:0] MAGIC_LIVE = 32'h4C49_5645;
    localparam logic [31:0] MAGIC_PIRS = 32'h5049_5253;

    // Line codes: empty, or 1 + magic kind
    typedef logic [1:0] t_code;
    localparam t_code CODE_EMPTY = 2'd0;
    localparam t_code CODE_CON   = 2'd1;
    localparam t_code CODE_LIVE  = 2'd2;
    localparam t_code CODE_PIRS  = 2'd3;

    localparam logic [31:0] GOOD_TYPES [8] = '{
        32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
        32'h000D_0000, 32'h0009_0000, 32'h0004_0000, 32'h000B_0000
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [47:0] header_offset;
        logic [1:0]  magic_kind;
        logic [31:0] title_word;
        logic [31:0] type_word;
    } t_out_word;

    // Typed line entry: code plus captured content type
    typedef struct packed {
        t_code       code;
        logic [31:0] type_word;
    } t_typed_entry;

    // Final line entry: fully checked candidate
    typedef struct packed {
        t_code       code;
        logic [31:0] title_word;
        logic [31:0] type_word;
    } t_final_entry;

    function automatic logic type_ok(input logic [31:0] w);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (w == GOOD_TYPES[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_code magic_code(input logic [31:0] w);
        t_code c;
        c = CODE_EMPTY;
        if (w == MAGIC_CON) begin
            c = CODE_CON;
        end
        if (w == MAGIC_LIVE) begin
            c = CODE_LIVE;
        end
        if (w == MAGIC_PIRS) begin
            c = CODE_PIRS;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/shc_ram.sv
// ============================================================================
// shc_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ============================================================================
`default_nettype none

module shc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/signed_header_carver_unit.sv
// ============================================================================
// signed_header_carver_unit
// Byte-stream scanner that finds container magics and checks their headers.
// ============================================================================
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_ready | data_byte, end_of_stream
//  out      | output    | o_out_valid/i_out_ready | offset, kind, title, type
//  cfg      | input     | i_cfg_valid/o_cfg_ready | max_version (8 bits)
//
//  One byte per cycle sustained unless the output stalls. A byte passes four
//  stages: accept (magic line access), typed line access, final line access,
//  output register. A header is reported from the output register once its
//  last byte has passed the typed and final line stages. Reset is synchronous
//  and active low; no memory sweep is needed because a fill counter masks line
//  entries not yet written since the last clear. Stages collapse bubbles: a
//  stalled output only blocks input once every stage behind it is occupied.
//
`default_nettype none

module signed_header_carver_unit #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire shc_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output shc_pkg::t_out_word      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data
);

    import shc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [7:0] r_max_version;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_version <= MAX_VERSION_RST;
        end else if (i_cfg_valid) begin
            r_max_version <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Flow control: each stage frees when the one ahead can take its word
    // ------------------------------------------------------------------
    logic r_b_v, r_c_v, r_d_v;
    logic d_has, d_free, c_free, b_free;
    logic acc, adv_bc, adv_cd;

    assign d_free = !r_d_v || !d_has || i_out_ready;
    assign c_free = !r_c_v || d_free;
    assign b_free = !r_b_v || c_free;
    assign acc    = i_in_valid && b_free;
    assign adv_bc = r_b_v && c_free;
    assign adv_cd = r_c_v && d_free;

    assign o_in_ready = b_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (b_free) begin
                r_b_v <= i_in_valid;
            end
            if (c_free) begin
                r_c_v <= r_b_v;
            end
            if (d_free) begin
                r_d_v <= r_c_v;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: byte window, position, fill count and line heads
    // ------------------------------------------------------------------
    logic [55:0]            r_recent;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [FILL_W-1:0]      r_fill;
    logic [MAG_AW-1:0]      r_mhead;
    logic [TYP_AW-1:0]      r_thead;
    logic [FIN_AW-1:0]      r_fhead;

    logic [63:0]            n_window;
    logic [OFFSET_BITS-1:0] n_start;
    logic [FILL_W-1:0]      n_fill;
    logic [MAG_AW-1:0]      n_mhead;
    logic [TYP_AW-1:0]      n_thead;
    logic [FIN_AW-1:0]      n_fhead;
    t_code                  n_magic;
    logic                   a_mag_ok, a_typ_ok, a_fin_ok;

    assign n_window = {r_recent, i_in_data.data_byte};
    assign n_magic  = magic_code(n_window[31:0]);
    assign n_start  = r_pos - OFFSET_BITS'(HDR_LEN - 1);

    // An entry read before the line has been written depth times since the
    // last clear counts as empty.
    assign a_mag_ok = (r_fill == FILL_W'(MAGIC_DEPTH));
    assign a_typ_ok = (r_fill >= FILL_W'(TYPED_DEPTH));
    assign a_fin_ok = (r_fill >= FILL_W'(FINAL_DEPTH));
    assign n_fill   = a_mag_ok ? r_fill : r_fill + FILL_W'(1);

    assign n_mhead = (r_mhead == MAG_AW'(MAGIC_DEPTH - 1)) ? '0 : r_mhead + MAG_AW'(1);
    assign n_thead = (r_thead == TYP_AW'(TYPED_DEPTH - 1)) ? '0 : r_thead + TYP_AW'(1);
    assign n_fhead = (r_fhead == FIN_AW'(FINAL_DEPTH - 1)) ? '0 : r_fhead + FIN_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_pos    <= '0;
            r_fill   <= '0;
            r_mhead  <= '0;
        end else if (acc) begin
            if (i_in_data.end_of_stream) begin
                // end of stream: clear window, position, fill count and magic head
                r_recent <= '0;
                r_pos    <= '0;
                r_fill   <= '0;
                r_mhead  <= '0;
            end else begin
                r_recent <= n_window[55:0];
                r_pos    <= r_pos + OFFSET_BITS'(1);
                r_fill   <= n_fill;
                r_mhead  <= n_mhead;
            end
        end
    end

    // typed and final heads step with their own stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thead <= '0;
            r_fhead <= '0;
        end else begin
            if (adv_bc) begin
                r_thead <= n_thead;
            end
            if (adv_cd) begin
                r_fhead <= n_fhead;
            end
        end
    end

    // magic line: new code in, code from MAGIC_DEPTH bytes ago out
    t_code mag_rd;

    shc_ram #(
        .WIDTH ($bits(t_code)),
        .DEPTH (MAGIC_DEPTH)
    ) u_magic_line (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (r_mhead),
        .i_wdata (n_magic),
        .i_re    (acc),
        .i_raddr (r_mhead),
        .o_rdata (mag_rd)
    );

    // ------------------------------------------------------------------
    // Stage B: type word check
    // ------------------------------------------------------------------
    logic [31:0]            r_b_low, r_b_high;
    logic [OFFSET_BITS-1:0] r_b_start;
    logic                   r_b_mag_ok, r_b_typ_ok, r_b_fin_ok;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_low    <= n_window[31:0];
            r_b_high   <= n_window[63:32];
            r_b_start  <= n_start;
            r_b_mag_ok <= a_mag_ok;
            r_b_typ_ok <= a_typ_ok;
            r_b_fin_ok <= a_fin_ok;
        end
    end

    t_code        b_code;
    t_typed_entry n_typed;
    t_typed_entry typ_rd;

    assign b_code = r_b_mag_ok ? mag_rd : CODE_EMPTY;
    assign n_typed.code = (b_code != CODE_EMPTY && type_ok(r_b_low)) ? b_code : CODE_EMPTY;
    assign n_typed.type_word = r_b_low;

    shc_ram #(
        .WIDTH ($bits(t_typed_entry)),
        .DEPTH (TYPED_DEPTH)
    ) u_typed_line (
        .i_clk   (i_clk),
        .i_we    (adv_bc),
        .i_waddr (r_thead),
        .i_wdata (n_typed),
        .i_re    (adv_bc),
        .i_raddr (r_thead),
        .o_rdata (typ_rd)
    );

    // ------------------------------------------------------------------
    // Stage C: title nonzero and version limit
    // ------------------------------------------------------------------
    logic [31:0]            r_c_low, r_c_high;
    logic [OFFSET_BITS-1:0] r_c_start;
    logic                   r_c_typ_ok, r_c_fin_ok;

    always_ff @(posedge i_clk) begin
        if (adv_bc) begin
            r_c_low    <= r_b_low;
            r_c_high   <= r_b_high;
            r_c_start  <= r_b_start;
            r_c_typ_ok <= r_b_typ_ok;
            r_c_fin_ok <= r_b_fin_ok;
        end
    end

    t_code        c_code;
    logic         c_pass;
    t_final_entry n_final;
    t_final_entry fin_rd;

    assign c_code = r_c_typ_ok ? typ_rd.code : CODE_EMPTY;
    assign c_pass = (c_code != CODE_EMPTY) && (r_c_high != '0)
                 && (r_c_low <= {24'd0, r_max_version});
    assign n_final.code       = c_pass ? c_code : CODE_EMPTY;
    assign n_final.title_word = r_c_high;
    assign n_final.type_word  = typ_rd.type_word;

    shc_ram #(
        .WIDTH ($bits(t_final_entry)),
        .DEPTH (FINAL_DEPTH)
    ) u_final_line (
        .i_clk   (i_clk),
        .i_we    (adv_cd),
        .i_waddr (r_fhead),
        .i_wdata (n_final),
        .i_re    (adv_cd),
        .i_raddr (r_fhead),
        .o_rdata (fin_rd)
    );

    // ------------------------------------------------------------------
    // Stage D: output register (final line read data plus start offset)
    // ------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] r_d_start;
    logic                   r_d_fin_ok;
    logic [63:0]            d_start64;

    always_ff @(posedge i_clk) begin
        if (adv_cd) begin
            r_d_start  <= r_c_start;
            r_d_fin_ok <= r_c_fin_ok;
        end
    end

    // a word without a result simply drains from this stage
    assign d_has     = r_d_v && r_d_fin_ok && (fin_rd.code != CODE_EMPTY);
    assign d_start64 = 64'(r_d_start);

    assign o_out_valid              = d_has;
    assign o_out_data.header_offset = d_start64[47:0];
    assign o_out_data.magic_kind    = fin_rd.code - 2'd1;
    assign o_out_data.title_word    = fin_rd.title_word;
    assign o_out_data.type_word     = fin_rd.type_word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAGIC_DEPTH))
        else $error("fill count past magic line depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mhead < MAG_AW'(MAGIC_DEPTH)) && (r_fhead < FIN_AW'(FINAL_DEPTH)))
        else $error("line head out of range");

    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_data.end_of_stream) |=> (r_fill == '0) && (r_pos == '0))
        else $error("end of stream did not clear position and fill");

    a_flag_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && r_b_mag_ok) |-> (r_b_typ_ok && r_b_fin_ok))
        else $error("line fill flags inconsistent");

    a_out_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_d_v && r_d_fin_ok))
        else $error("result from unfilled final line");

endmodule

`default_nettype wire
